/* rtl/indexed_list_engine_defines.svh */
// Assertion macros used by the indexed list engine datapath.
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ILE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ILE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ile_pkg.sv */
// Types, codes and constants shared by the indexed list engine modules.
package ile_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int FUNC_W    = 4;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 7;
    localparam int INDEX_W   = 6;
    localparam int LEN_W     = 7;
    localparam int STATUS_W  = 3;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND       = 4'd0,
        FN_INSERT       = 4'd1,
        FN_REMOVE_AT    = 4'd2,
        FN_REMOVE_VALUE = 4'd3,
        FN_FIND         = 4'd4,
        FN_READ_AT      = 4'd5,
        FN_FIRST        = 4'd6,
        FN_LAST         = 4'd7,
        FN_MIDDLE       = 4'd8,
        FN_CLEAR        = 4'd9
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_RANGE     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        CUR_HOLD,
        CUR_INC,
        CUR_DEC,
        CUR_ZERO,
        CUR_POS,
        CUR_CNT,
        CUR_LAST,
        CUR_MID,
        CUR_NEXT
    } cur_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_UP,
        S_WRITE_VAL,
        S_RD_ISSUE,
        S_RD_CAP,
        S_REM_ISSUE,
        S_REM_CAP,
        S_SHIFT_DOWN,
        S_SEARCH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    ld_req;
        cur_op_t cur_op;
        logic    rd_en;
        logic    rd_prev;
        logic    mv_up;
        logic    mv_dn;
        logic    wr_val;
        logic    cap_data;
        logic    cap_idx;
        cnt_op_t cnt_op;
        logic    st_we;
        status_t st_code;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              ins_gt_cnt;
        logic              pos_ge_cnt;
        logic              full;
        logic              empty;
        logic              cur_gt_ins;
        logic              cur_lt_cnt;
        logic              hit;
        logic              rd_vld;
        logic              out_free;
    } dp_stat_t;

endpackage

/* rtl/indexed_list_engine.sv */
// Indexed list engine top level: controller plus datapath on stream ports.
// Failed, clear and no-op requests finish straight from decode; insert, remove and search
//   walk the list one entry at a time.
// Throughput: one item at a time; the walk through the single-read-port entry
//   RAM sets the rate. A new item is taken while the previous result waits.
// Reset: list length cleared synchronously; entry storage is not cleared.
module indexed_list_engine #(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // func[3:0], item_value[35:4], position[42:36], zero pad[47:43]
    input  logic [ile_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // data_out[31:0], index_out[37:32], length_out[44:38], status[47:45]
    output logic [ile_pkg::M_TDATA_W-1:0] m_tdata
);

    ile_pkg::dp_cmd_t  cmd;
    ile_pkg::dp_stat_t stat;

    ile_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ile_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

/* rtl/ile_ram.sv */
// Generic simple dual-port RAM, one write port and one registered read port.
module ile_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ile_ctrl.sv */
// Controller state machine: sequences reads, shifts and searches of the list.
module ile_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  ile_pkg::dp_stat_t stat,
    output ile_pkg::dp_cmd_t  cmd
);

    ile_pkg::state_t state_reg;
    ile_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ile_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.cur_op  = ile_pkg::CUR_HOLD;
        cmd.cnt_op  = ile_pkg::CNT_HOLD;
        cmd.st_code = ile_pkg::ST_OK;
        s_tready    = 1'b0;
        case (state_reg)
            ile_pkg::S_IDLE: begin
                s_tready   = 1'b1;
                cmd.ld_req = s_tvalid;
                if (s_tvalid) begin
                    state_next = ile_pkg::S_DECODE;
                end
            end
            ile_pkg::S_DECODE: begin
                state_next = ile_pkg::S_DONE;
                case (stat.func)
                    ile_pkg::FN_APPEND, ile_pkg::FN_INSERT: begin
                        if (stat.ins_gt_cnt) begin
                            cmd.st_we   = 1'b1;
                            cmd.st_code = ile_pkg::ST_RANGE;
                        end else if (stat.full) begin
                            cmd.st_we   = 1'b1;
                            cmd.st_code = ile_pkg::ST_FULL;
                        end else begin
                            cmd.cur_op = ile_pkg::CUR_CNT;
                            state_next = ile_pkg::S_SHIFT_UP;
                        end
                    end
                    ile_pkg::FN_REMOVE_AT: begin
                        if (stat.pos_ge_cnt) begin
                            cmd.st_we   = 1'b1;
                            cmd.st_code = ile_pkg::ST_RANGE;
                        end else begin
                            cmd.cur_op = ile_pkg::CUR_POS;
                            state_next = ile_pkg::S_REM_ISSUE;
                        end
                    end
                    ile_pkg::FN_REMOVE_VALUE, ile_pkg::FN_FIND: begin
                        if (stat.empty) begin
                            cmd.st_we   = 1'b1;
                            cmd.st_code = ile_pkg::ST_NOT_FOUND;
                        end else begin
                            cmd.cur_op = ile_pkg::CUR_ZERO;
                            state_next = ile_pkg::S_SEARCH;
                        end
                    end
                    ile_pkg::FN_READ_AT: begin
                        if (stat.pos_ge_cnt) begin
                            cmd.st_we   = 1'b1;
                            cmd.st_code = ile_pkg::ST_RANGE;
                        end else begin
                            cmd.cur_op = ile_pkg::CUR_POS;
                            state_next = ile_pkg::S_RD_ISSUE;
                        end
                    end
                    ile_pkg::FN_FIRST, ile_pkg::FN_LAST, ile_pkg::FN_MIDDLE: begin
                        if (stat.empty) begin
                            cmd.st_we   = 1'b1;
                            cmd.st_code = ile_pkg::ST_EMPTY;
                        end else begin
                            if (stat.func == ile_pkg::FN_FIRST) begin
                                cmd.cur_op = ile_pkg::CUR_ZERO;
                            end else if (stat.func == ile_pkg::FN_LAST) begin
                                cmd.cur_op = ile_pkg::CUR_LAST;
                            end else begin
                                cmd.cur_op = ile_pkg::CUR_MID;
                            end
                            state_next = ile_pkg::S_RD_ISSUE;
                        end
                    end
                    ile_pkg::FN_CLEAR: begin
                        cmd.cnt_op = ile_pkg::CNT_CLR;
                    end
                    default: begin
                        state_next = ile_pkg::S_DONE;
                    end
                endcase
            end
            // walk down from the tail, moving each entry one place up
            ile_pkg::S_SHIFT_UP: begin
                cmd.mv_up = 1'b1;
                if (stat.cur_gt_ins) begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_prev = 1'b1;
                    cmd.cur_op  = ile_pkg::CUR_DEC;
                end else begin
                    state_next = ile_pkg::S_WRITE_VAL;
                end
            end
            ile_pkg::S_WRITE_VAL: begin
                cmd.wr_val = 1'b1;
                cmd.cnt_op = ile_pkg::CNT_INC;
                state_next = ile_pkg::S_DONE;
            end
            ile_pkg::S_RD_ISSUE: begin
                cmd.rd_en  = 1'b1;
                state_next = ile_pkg::S_RD_CAP;
            end
            ile_pkg::S_RD_CAP: begin
                cmd.cap_data = 1'b1;
                state_next   = ile_pkg::S_DONE;
            end
            ile_pkg::S_REM_ISSUE: begin
                cmd.rd_en  = 1'b1;
                state_next = ile_pkg::S_REM_CAP;
            end
            ile_pkg::S_REM_CAP: begin
                cmd.cap_data = 1'b1;
                cmd.cur_op   = ile_pkg::CUR_NEXT;
                state_next   = ile_pkg::S_SHIFT_DOWN;
            end
            // walk up from the gap, moving each entry one place down
            ile_pkg::S_SHIFT_DOWN: begin
                cmd.mv_dn = 1'b1;
                if (stat.cur_lt_cnt) begin
                    cmd.rd_en  = 1'b1;
                    cmd.cur_op = ile_pkg::CUR_INC;
                end else begin
                    cmd.cnt_op = ile_pkg::CNT_DEC;
                    state_next = ile_pkg::S_DONE;
                end
            end
            ile_pkg::S_SEARCH: begin
                if (stat.hit) begin
                    cmd.cap_data = 1'b1;
                    cmd.cap_idx  = 1'b1;
                    if (stat.func == ile_pkg::FN_FIND) begin
                        state_next = ile_pkg::S_DONE;
                    end else begin
                        cmd.cur_op = ile_pkg::CUR_NEXT;
                        state_next = ile_pkg::S_SHIFT_DOWN;
                    end
                end else if (stat.cur_lt_cnt) begin
                    cmd.rd_en  = 1'b1;
                    cmd.cur_op = ile_pkg::CUR_INC;
                end else if (!stat.rd_vld) begin
                    cmd.st_we   = 1'b1;
                    cmd.st_code = ile_pkg::ST_NOT_FOUND;
                    state_next  = ile_pkg::S_DONE;
                end
            end
            ile_pkg::S_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ile_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ile_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/ile_dp.sv */
// Datapath: request registers, entry RAM, cursor, count and result register.
`include "indexed_list_engine_defines.svh"

module ile_dp #(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [ile_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [ile_pkg::M_TDATA_W-1:0]  m_tdata,
    input  ile_pkg::dp_cmd_t               cmd,
    output ile_pkg::dp_stat_t              stat
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PW  = ile_pkg::POS_W;
    localparam int W   = (CW > PW) ? CW : PW;
    localparam int IXW = (AW > ile_pkg::INDEX_W) ? AW : ile_pkg::INDEX_W;
    localparam int LXW = (CW > ile_pkg::LEN_W) ? CW : ile_pkg::LEN_W;
    localparam int VW  = ile_pkg::VALUE_W;
    localparam int FW  = ile_pkg::FUNC_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [FW-1:0]                 func_reg, func_next;
    logic [VW-1:0]                 val_reg, val_next;
    logic [PW-1:0]                 pos_reg, pos_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [CW-1:0]                 cur_reg, cur_next;
    logic [AW-1:0]                 rd_addr_reg, rd_addr_next;
    logic                          rd_vld_reg, rd_vld_next;
    logic [VW-1:0]                 data_reg, data_next;
    logic [AW-1:0]                 idx_reg, idx_next;
    ile_pkg::status_t              st_reg, st_next;
    logic                          m_valid_reg, m_valid_next;
    logic [ile_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [W-1:0]   pos_w, cnt_w, cur_w, ins_w;
    logic [AW-1:0]  rd_addr;
    logic [VW-1:0]  rd_data;
    logic           hit;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [VW-1:0]  wr_data;
    logic [IXW-1:0] idx_wide;
    logic [LXW-1:0] len_wide;

    assign pos_w = W'(pos_reg);
    assign cnt_w = W'(cnt_reg);
    assign cur_w = W'(cur_reg);
    assign ins_w = (func_reg == ile_pkg::FN_APPEND) ? cnt_w : pos_w;

    assign rd_addr = cmd.rd_prev ? AW'(cur_reg - CW'(1)) : cur_reg[AW-1:0];
    assign hit     = rd_vld_reg && (rd_data == val_reg);

    assign wr_en   = cmd.wr_val || (rd_vld_reg && (cmd.mv_up || cmd.mv_dn));
    assign wr_addr = cmd.wr_val ? ins_w[AW-1:0] :
                     (cmd.mv_up ? rd_addr_reg + AW'(1) : rd_addr_reg - AW'(1));
    assign wr_data = cmd.wr_val ? val_reg : rd_data;

    ile_ram #(
        .WIDTH (VW),
        .DEPTH (CAPACITY)
    ) u_entries (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb begin
        stat.func       = func_reg;
        stat.ins_gt_cnt = ins_w > cnt_w;
        stat.pos_ge_cnt = pos_w >= cnt_w;
        stat.full       = cnt_reg >= CAP_C;
        stat.empty      = cnt_reg == '0;
        stat.cur_gt_ins = cur_w > ins_w;
        stat.cur_lt_cnt = cur_reg < cnt_reg;
        stat.hit        = hit;
        stat.rd_vld     = rd_vld_reg;
        stat.out_free   = !m_valid_reg || m_tready;
    end

    always_comb begin
        func_next = func_reg;
        val_next  = val_reg;
        pos_next  = pos_reg;
        data_next = data_reg;
        idx_next  = idx_reg;
        st_next   = st_reg;
        if (cmd.ld_req) begin
            func_next = s_tdata[FW-1:0];
            val_next  = s_tdata[FW+VW-1:FW];
            pos_next  = s_tdata[FW+VW+PW-1:FW+VW];
            data_next = '0;
            idx_next  = '0;
            st_next   = ile_pkg::ST_OK;
        end
        if (cmd.cap_data) begin
            data_next = rd_data;
        end
        if (cmd.cap_idx) begin
            idx_next = rd_addr_reg;
        end
        if (cmd.st_we) begin
            st_next = cmd.st_code;
        end
    end

    always_comb begin
        case (cmd.cur_op)
            ile_pkg::CUR_INC:  cur_next = cur_reg + CW'(1);
            ile_pkg::CUR_DEC:  cur_next = cur_reg - CW'(1);
            ile_pkg::CUR_ZERO: cur_next = '0;
            ile_pkg::CUR_POS:  cur_next = CW'(pos_w);
            ile_pkg::CUR_CNT:  cur_next = cnt_reg;
            ile_pkg::CUR_LAST: cur_next = cnt_reg - CW'(1);
            ile_pkg::CUR_MID:  cur_next = cnt_reg >> 1;
            ile_pkg::CUR_NEXT: cur_next = CW'(rd_addr_reg) + CW'(1);
            default:           cur_next = cur_reg;
        endcase
    end

    always_comb begin
        case (cmd.cnt_op)
            ile_pkg::CNT_INC: cnt_next = cnt_reg + CW'(1);
            ile_pkg::CNT_DEC: cnt_next = cnt_reg - CW'(1);
            ile_pkg::CNT_CLR: cnt_next = '0;
            default:          cnt_next = cnt_reg;
        endcase
    end

    assign rd_addr_next = cmd.rd_en ? rd_addr : rd_addr_reg;
    assign rd_vld_next  = cmd.rd_en;

    assign idx_wide = IXW'(idx_reg);
    assign len_wide = LXW'(cnt_reg);

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        m_tdata_next = m_tdata_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            m_tdata_next = {st_reg, len_wide[ile_pkg::LEN_W-1:0],
                            idx_wide[ile_pkg::INDEX_W-1:0], data_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        val_reg     <= val_next;
        pos_reg     <= pos_next;
        cur_reg     <= cur_next;
        rd_addr_reg <= rd_addr_next;
        data_reg    <= data_next;
        idx_reg     <= idx_next;
        st_reg      <= st_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

    `ILE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CAP_C, "entry count above capacity")
    `ILE_ASSERT_IMP(a_wr_in_list, wr_en, W'(wr_addr) <= cnt_w, "write beyond list end")
    `ILE_ASSERT_IMP(a_out_free, cmd.out_load, !m_valid_reg || m_tready, "result overwritten")
    `ILE_ASSERT_NXT(a_len_step, 1'b1, (cnt_reg == $past(cnt_reg)) || (cnt_reg == '0) || (cnt_reg == $past(cnt_reg) + CW'(1)) || (cnt_reg == $past(cnt_reg) - CW'(1)), "length jumped")

endmodule
